// File: rtl/core/tccs_pkg.sv
// package for the text console scrollback block
// holds geometry defaults, character codes, fsm state type and command/status structs
package tccs_pkg;

  localparam int unsigned LineWidthDefault   = 80;
  localparam int unsigned ScreenLinesDefault = 25;
  localparam int unsigned BufferLinesDefault = 64;

  localparam int unsigned AddrW = 13;
  localparam int unsigned LineW = 8;   // enough for up to 256 lines/columns

  localparam logic [7:0] ChNewline   = 8'd10;
  localparam logic [7:0] ChBackspace = 8'd8;
  localparam logic [7:0] ChBlank     = 8'd32;
  localparam logic [7:0] AttrReset   = 8'd7;

  localparam logic [1:0] OpPut  = 2'd0;
  localparam logic [1:0] OpUp   = 2'd1;
  localparam logic [1:0] OpDown = 2'd2;
  localparam logic [1:0] OpRead = 2'd3;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StPut,
    StWrapChk,
    StCopy,
    StCopyWr,
    StWrapBlank,
    StViewChk,
    StBlank,
    StRead,
    StReadWait,
    StOut
  } tccs_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic clear_step;   // write zero at sweep counter, advance
    logic load_in;      // capture input item
    logic do_put;       // apply put character to cursor and store
    logic do_scroll;    // apply scroll_view (dir from op / forced up)
    logic force_up;     // scroll up regardless of op
    logic wrap_init;    // start overflow handling
    logic copy_rd;      // read copy source
    logic copy_wr;      // write copy destination, advance
    logic blank_init;   // start line blank at cursor
    logic blank_step;   // write blank, advance
    logic view_step;    // count one view iteration
    logic view_init;    // reset view iteration counter
    logic read_rd;      // read addressed cell
    logic read_cap;     // capture read data
    logic out_load;     // load output register
  } tccs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_done;
    logic is_put;
    logic is_read;
    logic overflow;
    logic copy_last;
    logic blank_last;
    logic in_view;
    logic view_limit;
    logic out_full;
  } tccs_sts_t;

endpackage

// File: rtl/core/tccs_ctrl.sv
// controller state machine for the text console scrollback block
// depends on tccs_pkg for state type and command/status structs
module tccs_ctrl
  import tccs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tccs_sts_t sts_i,
  output tccs_cmd_t cmd_o
);

  tccs_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) state_d = StIdle;
      end
      StIdle: begin
        in_ready_o = !sts_i.out_full;
        if (in_valid_i && !sts_i.out_full) begin
          cmd_o.load_in = 1'b1;
          state_d = StPut;
        end
      end
      StPut: begin
        if (sts_i.is_put) begin
          cmd_o.do_put = 1'b1;
          state_d = StWrapChk;
        end else if (sts_i.is_read) begin
          cmd_o.read_rd = 1'b1;
          state_d = StReadWait;
        end else begin
          cmd_o.do_scroll = 1'b1;
          state_d = StOut;
        end
      end
      StWrapChk: begin
        cmd_o.view_init = 1'b1;
        if (sts_i.overflow) begin
          cmd_o.wrap_init = 1'b1;
          state_d = StCopy;
        end else begin
          state_d = StViewChk;
        end
      end
      StCopy: begin
        cmd_o.copy_rd = 1'b1;
        state_d = StCopyWr;
      end
      StCopyWr: begin
        cmd_o.copy_wr = 1'b1;
        if (sts_i.copy_last) begin
          cmd_o.blank_init = 1'b1;
          state_d = StWrapBlank;
        end else begin
          state_d = StCopy;
        end
      end
      StWrapBlank: begin
        cmd_o.blank_step = 1'b1;
        if (sts_i.blank_last) state_d = StViewChk;
      end
      StViewChk: begin
        if (sts_i.in_view || sts_i.view_limit) begin
          state_d = StOut;
        end else begin
          cmd_o.do_scroll  = 1'b1;
          cmd_o.force_up   = 1'b1;
          cmd_o.view_step  = 1'b1;
          cmd_o.blank_init = 1'b1;
          state_d = StBlank;
        end
      end
      StBlank: begin
        cmd_o.blank_step = 1'b1;
        if (sts_i.blank_last) state_d = StViewChk;
      end
      StReadWait: begin
        cmd_o.read_cap = 1'b1;
        state_d = StOut;
      end
      StRead: begin
        state_d = StOut;
      end
      StOut: begin
        cmd_o.out_load = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// File: rtl/core/tccs_dp.sv
// datapath for the text console scrollback block: cell store, cursor, view, output register
// depends on tccs_pkg for codes, widths and command/status structs
module tccs_dp
  import tccs_pkg::*;
#(
  parameter int unsigned LineWidth   = LineWidthDefault,
  parameter int unsigned ScreenLines = ScreenLinesDefault,
  parameter int unsigned BufferLines = BufferLinesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic [1:0]       op_i,
  input  logic [7:0]       char_code_i,
  input  logic [AddrW-1:0] cell_addr_i,
  input  tccs_cmd_t        cmd_i,
  output tccs_sts_t        sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [AddrW-1:0] cursor_pos_o,
  output logic [AddrW-1:0] view_start_o,
  output logic             buffer_full_o,
  output logic [7:0]       read_char_o,
  output logic [7:0]       read_attr_o
);

  localparam int unsigned BufCells = LineWidth * BufferLines;
  localparam int unsigned ScrCells = LineWidth * ScreenLines;
  localparam int unsigned CopyN    = ScrCells - LineWidth;
  localparam int unsigned IdxW     = $clog2(BufCells);
  localparam int unsigned ColW     = $clog2(LineWidth);
  localparam int unsigned VcntW    = $clog2(BufferLines + 3);

  localparam logic [AddrW:0] BufC  = (AddrW+1)'(BufCells);
  localparam logic [AddrW:0] ScrC  = (AddrW+1)'(ScrCells);
  localparam logic [AddrW:0] LwC   = (AddrW+1)'(LineWidth);
  localparam logic [AddrW:0] CpyC  = (AddrW+1)'(CopyN);
  localparam logic [AddrW:0] BmsC  = (AddrW+1)'(BufCells - ScrCells);

  // cell store, char low byte and attribute high byte
  logic [15:0] mem_q [BufCells];
  logic        we;
  logic [IdxW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata_q;
  logic        re;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  logic [7:0]       attr_q;
  logic [1:0]       op_q;
  logic [7:0]       ch_q;
  logic [AddrW-1:0] addr_q;
  logic [AddrW:0]   cur_q, cur_d, sov_q, sov_d;
  logic             wrap_q, wrap_d;
  logic [AddrW:0]   cnt_q, cnt_d;     // clear sweep / copy / blank position
  logic [AddrW:0]   end_q, end_d;     // blank end
  logic [AddrW:0]   src_q, src_d;     // copy source
  logic [VcntW-1:0] vcnt_q;
  logic [ColW-1:0]  col_q;            // cursor column
  logic [ColW-1:0]  col_d;
  logic             src_ok_q;
  logic [15:0]      rd_q, rd_d;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= AttrReset;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= op_i;
      ch_q   <= char_code_i;
      addr_q <= cell_addr_i;
    end
  end

  // scroll_view next view start
  function automatic logic [AddrW:0] scroll_fn(input logic down, input logic [AddrW:0] cur,
                                               input logic [AddrW:0] sov, input logic wr);
    logic [AddrW:0] oldest, r;
    logic [AddrW+1:0] tmp;
    begin
      tmp    = {1'b0, cur} + {1'b0, LwC};
      oldest = (tmp >= {1'b0, BufC}) ? (AddrW+1)'(tmp - {1'b0, BufC}) : tmp[AddrW:0];
      if (!wr) oldest = '0;
      r = sov;
      if (down) begin
        if (!wr && sov != '0) begin
          r = sov - LwC;
        end else if (wr && sov != oldest) begin
          if (cur >= BmsC) begin
            if (sov != '0) r = sov - LwC;
          end else if (sov == '0) begin
            r = BmsC;
          end else begin
            r = sov - LwC;
          end
        end
      end else begin
        if (!wr && cur >= sov + ScrC) begin
          r = sov + LwC;
        end else if (wr && sov + ScrC - LwC != cur) begin
          if (sov + ScrC == BufC) r = '0;
          else r = sov + LwC;
        end
      end
      return r;
    end
  endfunction

  // cursor, view, counters and store port control
  always_comb begin
    cur_d  = cur_q;
    sov_d  = sov_q;
    wrap_d = wrap_q;
    cnt_d  = cnt_q;
    end_d  = end_q;
    src_d  = src_q;
    col_d  = col_q;
    rd_d   = rd_q;
    we     = 1'b0;
    waddr  = cnt_q[IdxW-1:0];
    wdata  = {attr_q, ChBlank};
    re     = 1'b0;
    raddr  = src_q[IdxW-1:0];

    if (cmd_i.clear_step) begin
      we    = 1'b1;
      wdata = '0;
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.load_in) cnt_d = '0;

    if (cmd_i.do_put) begin
      if (ch_q == ChNewline) begin
        cur_d = cur_q + LwC - (AddrW+1)'(col_q);
        col_d = '0;
      end else if (ch_q == ChBackspace) begin
        if (cur_q != '0) begin
          cur_d = cur_q - 1'b1;
          col_d = (col_q == '0) ? ColW'(LineWidth - 1) : col_q - 1'b1;
          we    = 1'b1;
          waddr = cur_d[IdxW-1:0];
        end
      end else begin
        we    = 1'b1;
        waddr = cur_q[IdxW-1:0];
        wdata = {attr_q, ch_q};
        cur_d = cur_q + 1'b1;
        col_d = (col_q == ColW'(LineWidth - 1)) ? '0 : col_q + 1'b1;
      end
    end

    if (cmd_i.do_scroll) begin
      sov_d = scroll_fn(!cmd_i.force_up && op_q == OpDown, cur_q, sov_q, wrap_q);
    end

    if (cmd_i.wrap_init) begin
      // source row start: (row+1)*W - scr = cur - col + W - scr
      src_d  = cur_q - (AddrW+1)'(col_q) + LwC - ScrC;
      cnt_d  = '0;
      sov_d  = '0;
      cur_d  = CpyC + (AddrW+1)'(col_q);
      wrap_d = 1'b1;
    end

    if (cmd_i.copy_rd) re = 1'b1;
    if (cmd_i.copy_wr) begin
      we    = 1'b1;
      waddr = cnt_q[IdxW-1:0];
      wdata = src_ok_q ? rdata_q : '0;
      cnt_d = cnt_q + 1'b1;
      src_d = src_q + 1'b1;
    end

    if (cmd_i.blank_init) begin
      cnt_d = cur_d;
      end_d = cur_d + LwC;
    end
    if (cmd_i.blank_step) begin
      we    = (cnt_q < BufC);
      waddr = cnt_q[IdxW-1:0];
      cnt_d = cnt_q + 1'b1;
    end

    if (cmd_i.read_rd) begin
      re    = 1'b1;
      raddr = addr_q[IdxW-1:0];
    end
    if (cmd_i.read_cap) begin
      rd_d = ({1'b0, addr_q} < BufC) ? rdata_q : '0;
    end
    if (cmd_i.load_in) rd_d = '0;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      sov_q  <= '0;
      wrap_q <= 1'b0;
      cnt_q  <= '0;
      col_q  <= '0;
      vcnt_q <= '0;
    end else begin
      cur_q  <= cur_d;
      sov_q  <= sov_d;
      wrap_q <= wrap_d;
      cnt_q  <= cnt_d;
      col_q  <= col_d;
      if (cmd_i.view_init) vcnt_q <= '0;
      else if (cmd_i.view_step) vcnt_q <= vcnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q    <= end_d;
    src_q    <= src_d;
    rd_q     <= rd_d;
    src_ok_q <= (src_q < BufC);
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cursor_pos_o  <= cur_q[AddrW-1:0];
      view_start_o  <= sov_q[AddrW-1:0];
      buffer_full_o <= wrap_q;
      read_char_o   <= rd_q[7:0];
      read_attr_o   <= rd_q[15:8];
    end
  end

  assign out_valid_o = out_valid_q;

  // status back to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.clear_done = (cnt_q == BufC - 1'b1);
    sts_o.is_put     = (op_q == OpPut);
    sts_o.is_read    = (op_q == OpRead);
    sts_o.overflow   = (cur_q >= BufC);
    sts_o.copy_last  = (cnt_q == CpyC - 1'b1);
    sts_o.blank_last = (cnt_q == end_q - 1'b1);
    sts_o.in_view    = (cur_q < sov_q + ScrC) && (cur_q >= sov_q);
    sts_o.view_limit = (vcnt_q == VcntW'(BufferLines + 2));
    sts_o.out_full   = out_valid_q && !out_ready_i;
  end

endmodule

// File: rtl/core/text_console_cursor_scroll.sv
// text console over a scrollback cell store; one transaction in flight at a time
// a put that overflows the store copies cells and blanks a line before the view check;
// each view scroll then blanks the cursor line; input waits while a result is not taken
// after reset a clearing pass zeroes the store and no item is accepted meanwhile;
// char_attribute resets to 7
module text_console_cursor_scroll
  import tccs_pkg::*;
#(
  parameter int unsigned LINE_WIDTH   = LineWidthDefault,
  parameter int unsigned SCREEN_LINES = ScreenLinesDefault,
  parameter int unsigned BUFFER_LINES = BufferLinesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // op[1:0], char_code[9:2], cell_addr[22:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // cursor_pos[12:0], view_start[25:13],
                                      // buffer_full[26], read_char[34:27], read_attr[42:35]
);

  tccs_cmd_t cmd;
  tccs_sts_t sts;
  logic [AddrW-1:0] cursor_pos, view_start;
  logic             buffer_full;
  logic [7:0]       read_char, read_attr;

  tccs_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tccs_dp #(
    .LineWidth   (LINE_WIDTH),
    .ScreenLines (SCREEN_LINES),
    .BufferLines (BUFFER_LINES)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .op_i          (s_axis_tdata[1:0]),
    .char_code_i   (s_axis_tdata[9:2]),
    .cell_addr_i   (s_axis_tdata[22:10]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .cursor_pos_o  (cursor_pos),
    .view_start_o  (view_start),
    .buffer_full_o (buffer_full),
    .read_char_o   (read_char),
    .read_attr_o   (read_attr)
  );

  assign m_axis_tdata = {5'd0, read_attr, read_char, buffer_full, view_start, cursor_pos};

endmodule
